// ===== rtl/spiacc_pkg.sv =====
// Package with the transaction types, codes and payload structs of the SPI register master.
`timescale 1ns / 1ps

package spiacc_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SETUP = 2'd1,
    PH_LOW   = 2'd2,
    PH_HIGH  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_BURST = 2'd3
  } kind_e;

  localparam logic [7:0] READ_FLAG   = 8'h80;
  localparam logic [7:0] BURST_FLAG  = 8'hC0;
  localparam logic [7:0] BURST_ADDR  = 8'h32;
  localparam logic [7:0] DUMMY_BYTE  = 8'h00;
  localparam logic [2:0] LAST_BIT    = 3'd7;
  localparam logic [2:0] LAST_RD     = 3'd1;
  localparam logic [2:0] LAST_BURST  = 3'd6;
  localparam int unsigned NUM_AXES   = 3;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] reg_addr;
    logic [7:0] write_data;
    logic       miso;
  } in_item_t;

  typedef struct packed {
    logic               cs_n;
    logic               sclk;
    logic               mosi;
    logic               busy_res;
    logic               done_res;
    logic [7:0]         read_data;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } out_item_t;

endpackage

// ===== rtl/spi_accel_register_master_unit.sv =====
// Top level of the SPI mode 3 register master: one input item is one bit-timing tick.
// The result of an accepted item is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle; the input stalls only while a held result is stalled.
// Each item is handled by short logic between the state registers and the result register.
// Reset: asynchronous, active low; the unit goes idle with half_ticks_q at 1 and the stored
// read and axis data at zero; the output data register itself is not reset.
`timescale 1ns / 1ps

module spi_accel_register_master_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  spiacc_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output spiacc_pkg::out_item_t out_data_o
);
  import spiacc_pkg::*;

  logic [7:0]  half_ticks_q;
  phase_e      phase_q, phase_s, phase_d;
  kind_e       kind_q, kind_s, kind_d;
  logic [7:0]  tick_q, tick_s, tick_d;
  logic [2:0]  bit_q, bit_s, bit_d;
  logic [2:0]  byte_q, byte_s, byte_d;
  logic [7:0]  tx_q, tx_s, tx_d;
  logic [7:0]  rx_q, rx_s, rx_d;
  logic [7:0]  saved_q, saved_s, saved_d;
  logic [7:0]  latched_q, latched_d;
  logic [15:0] axis_q [NUM_AXES];
  logic [15:0] axis_d [NUM_AXES];

  logic        accept;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q;
  out_item_t   result;
  logic        done;
  logic [7:0]  half_len;
  logic        half_end;
  logic [2:0]  last_byte;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A start command is taken only while idle; this sets up the state the tick works on.
  always_comb begin
    phase_s = phase_q;
    kind_s  = kind_q;
    tick_s  = tick_q;
    bit_s   = bit_q;
    byte_s  = byte_q;
    tx_s    = tx_q;
    rx_s    = rx_q;
    saved_s = saved_q;
    if (phase_q == PH_IDLE && kind_e'(in_data_i.command) != KIND_NONE) begin
      kind_s = kind_e'(in_data_i.command);
      tick_s = '0;
      bit_s  = '0;
      byte_s = '0;
      rx_s   = '0;
      unique case (kind_e'(in_data_i.command))
        KIND_WRITE: begin
          tx_s    = {2'b00, in_data_i.reg_addr};
          saved_s = in_data_i.write_data;
          phase_s = PH_SETUP;
        end
        KIND_READ: begin
          tx_s    = READ_FLAG | {2'b00, in_data_i.reg_addr};
          phase_s = PH_LOW;
        end
        KIND_BURST: begin
          tx_s    = BURST_FLAG | BURST_ADDR;
          phase_s = PH_LOW;
        end
        KIND_NONE: begin
          phase_s = PH_IDLE;
        end
      endcase
    end
  end

  assign half_len  = (half_ticks_q == 8'd0) ? 8'd1 : half_ticks_q;
  assign half_end  = ({1'b0, tick_s} + 9'd1) >= {1'b0, half_len};
  assign last_byte = (kind_s == KIND_BURST) ? LAST_BURST : LAST_RD;

  // Next state of the tick.
  always_comb begin
    phase_d   = phase_s;
    kind_d    = kind_s;
    tick_d    = tick_s;
    bit_d     = bit_s;
    byte_d    = byte_s;
    tx_d      = tx_s;
    rx_d      = rx_s;
    saved_d   = saved_s;
    latched_d = latched_q;
    axis_d    = axis_q;
    done      = 1'b0;
    if (phase_s != PH_IDLE) begin
      if (half_end) begin
        tick_d = '0;
        unique case (phase_s)
          PH_SETUP: phase_d = PH_LOW;
          PH_LOW: begin
            rx_d    = {rx_s[6:0], in_data_i.miso};
            phase_d = PH_HIGH;
          end
          PH_HIGH: begin
            tx_d = {tx_s[6:0], 1'b0};
            if (bit_s == LAST_BIT) begin
              bit_d = '0;
              // End of a byte: store what came in, then move on or finish.
              if (kind_s == KIND_READ && byte_s == LAST_RD) begin
                latched_d = rx_s;
              end else if (kind_s == KIND_BURST) begin
                if (byte_s == 3'd1 || byte_s == 3'd3 || byte_s == 3'd5) begin
                  saved_d = rx_s;
                end else if (byte_s == 3'd2) begin
                  axis_d[0] = {rx_s, saved_s};
                end else if (byte_s == 3'd4) begin
                  axis_d[1] = {rx_s, saved_s};
                end else if (byte_s == 3'd6) begin
                  axis_d[2] = {rx_s, saved_s};
                end
              end
              if (byte_s >= last_byte) begin
                phase_d = PH_IDLE;
                byte_d  = '0;
                done    = 1'b1;
              end else begin
                byte_d  = byte_s + 3'd1;
                tx_d    = (kind_s == KIND_WRITE) ? saved_s : DUMMY_BYTE;
                phase_d = PH_LOW;
              end
            end else begin
              bit_d   = bit_s + 3'd1;
              phase_d = PH_LOW;
            end
          end
          PH_IDLE: phase_d = PH_IDLE;
        endcase
      end else begin
        tick_d = tick_s + 8'd1;
      end
    end
  end

  // Pin levels and status for this tick.
  always_comb begin
    result.cs_n      = (phase_s == PH_IDLE);
    result.sclk      = (phase_s != PH_LOW);
    result.mosi      = (phase_s != PH_IDLE) & tx_s[7];
    result.busy_res  = (phase_s != PH_IDLE);
    result.done_res  = done;
    result.read_data = latched_d;
    result.accel_x   = axis_d[0];
    result.accel_y   = axis_d[1];
    result.accel_z   = axis_d[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_ticks_q <= 8'd1;
      phase_q      <= PH_IDLE;
      kind_q       <= KIND_NONE;
      tick_q       <= '0;
      bit_q        <= '0;
      byte_q       <= '0;
      tx_q         <= '0;
      rx_q         <= '0;
      saved_q      <= '0;
      latched_q    <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_q[i] <= '0;
      end
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        half_ticks_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q   <= phase_d;
        kind_q    <= kind_d;
        tick_q    <= tick_d;
        bit_q     <= bit_d;
        byte_q    <= byte_d;
        tx_q      <= tx_d;
        rx_q      <= rx_d;
        saved_q   <= saved_d;
        latched_q <= latched_d;
        axis_q    <= axis_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= result;
    end
  end

endmodule

// ===== sim/spi_accel_register_master_unit_tb.sv =====
// Self-checking testbench for the SPI mode 3 accelerometer register master.
`timescale 1ns / 1ps

module spi_accel_register_master_unit_tb;
  import spiacc_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int MAX_PRINTED = 40;

  typedef enum logic [1:0] {
    FILL_NONE,
    FILL_LOW,
    FILL_HIGH,
    FILL_RAND
  } fill_e;

  // One row of the directed part. A row may first set the half length, then sends
  // its item reps times, then optionally ticks until the transaction has ended.
  typedef struct packed {
    logic       cfg_en;
    logic [7:0] cfg_val;
    in_item_t   item;
    logic [7:0] reps;
    fill_e      fill;
    logic       typed;
    out_item_t  want;
  } stim_row_t;

  localparam out_item_t IDLE_PINS = '{cs_n: 1'b1, sclk: 1'b1, default: '0};
  localparam out_item_t WRITE_SETUP = '{cs_n: 1'b0, sclk: 1'b1, mosi: 1'b0,
                                        busy_res: 1'b1, default: '0};

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  // Predicted state of the serial engine.
  phase_e      bus_phase = PH_IDLE;
  kind_e       bus_kind = KIND_NONE;
  logic [7:0]  half_ticks = 8'd1;
  logic [7:0]  tick_cnt = '0;
  logic [2:0]  bit_cnt = '0;
  logic [2:0]  byte_cnt = '0;
  logic [7:0]  tx_sr = '0;
  logic [7:0]  rx_sr = '0;
  logic [7:0]  low_byte = '0;
  logic [7:0]  rd_byte = '0;
  logic [15:0] axis [NUM_AXES] = '{default: '0};

  out_item_t expected_pins_q [$];
  stim_row_t dir_rows [$];
  int        mismatch_count = 0;
  int        result_count = 0;
  int        cycle_count = 0;
  int        stall_left = 0;
  bit        rx_calm = 1'b0;
  bit        tx_calm = 1'b0;

  spi_accel_register_master_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int pick_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 40);
  endfunction

  // Advances the predicted engine by one tick and returns the pins and data it drives.
  function automatic out_item_t predict_tick(input in_item_t it);
    out_item_t  r;
    int         half;
    int         ax;
    logic [2:0] last;
    logic       ends;
    half = (half_ticks == 8'd0) ? 1 : int'(half_ticks);
    ends = 1'b0;
    if (bus_phase == PH_IDLE && it.command != KIND_NONE) begin
      bus_kind = kind_e'(it.command);
      tick_cnt = '0;
      bit_cnt = '0;
      byte_cnt = '0;
      rx_sr = '0;
      case (bus_kind)
        KIND_WRITE: begin
          tx_sr = {2'b00, it.reg_addr};
          low_byte = it.write_data;
          bus_phase = PH_SETUP;
        end
        KIND_READ: begin
          tx_sr = READ_FLAG | {2'b00, it.reg_addr};
          bus_phase = PH_LOW;
        end
        default: begin
          tx_sr = BURST_FLAG | BURST_ADDR;
          bus_phase = PH_LOW;
        end
      endcase
    end
    r = '0;
    if (bus_phase == PH_IDLE) begin
      r.cs_n = 1'b1;
      r.sclk = 1'b1;
    end else begin
      r.sclk = (bus_phase != PH_LOW);
      r.mosi = tx_sr[7];
      r.busy_res = 1'b1;
      if (int'(tick_cnt) + 1 >= half) begin
        tick_cnt = '0;
        case (bus_phase)
          PH_SETUP: bus_phase = PH_LOW;
          PH_LOW: begin
            rx_sr = {rx_sr[6:0], it.miso};
            bus_phase = PH_HIGH;
          end
          default: begin
            tx_sr = tx_sr << 1;
            if (bit_cnt == LAST_BIT) begin
              bit_cnt = '0;
              if (bus_kind == KIND_READ && byte_cnt == LAST_RD) begin
                rd_byte = rx_sr;
              end else if (bus_kind == KIND_BURST && byte_cnt != 3'd0 &&
                           byte_cnt <= LAST_BURST) begin
                // Odd bytes are low halves; an axis changes whole on its high byte.
                if (byte_cnt[0]) begin
                  low_byte = rx_sr;
                end else begin
                  ax = int'(byte_cnt >> 1) - 1;
                  axis[ax] = {rx_sr, low_byte};
                end
              end
              last = (bus_kind == KIND_BURST) ? LAST_BURST : LAST_RD;
              if (byte_cnt >= last) begin
                bus_phase = PH_IDLE;
                byte_cnt = '0;
                ends = 1'b1;
              end else begin
                byte_cnt = byte_cnt + 3'd1;
                tx_sr = (bus_kind == KIND_WRITE) ? low_byte : DUMMY_BYTE;
                bus_phase = PH_LOW;
              end
            end else begin
              bit_cnt = bit_cnt + 3'd1;
              bus_phase = PH_LOW;
            end
          end
        endcase
      end else begin
        tick_cnt = tick_cnt + 8'd1;
      end
    end
    r.done_res = ends;
    r.read_data = rd_byte;
    r.accel_x = axis[0];
    r.accel_y = axis[1];
    r.accel_z = axis[2];
    return r;
  endfunction

  function automatic stim_row_t mk_row(input int cfg, input kind_e cmd, input logic [5:0] addr,
                                       input logic [7:0] wdata, input logic miso,
                                       input int reps, input fill_e fill,
                                       input logic typed = 1'b0,
                                       input out_item_t want = '0);
    stim_row_t row;
    row.cfg_en = (cfg >= 0);
    row.cfg_val = 8'(cfg);
    row.item = '{command: cmd, reg_addr: addr, write_data: wdata, miso: miso};
    row.reps = 8'(reps);
    row.fill = fill;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic cmp_field(input string name, input logic signed [63:0] got,
                           input logic signed [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_count, name, got, want));
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_pins_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
    end else begin
      want = expected_pins_q.pop_front();
      cmp_field("cs_n", got.cs_n, want.cs_n);
      cmp_field("sclk", got.sclk, want.sclk);
      cmp_field("mosi", got.mosi, want.mosi);
      cmp_field("busy_res", got.busy_res, want.busy_res);
      cmp_field("done_res", got.done_res, want.done_res);
      cmp_field("read_data", got.read_data, want.read_data);
      cmp_field("accel_x", got.accel_x, want.accel_x);
      cmp_field("accel_y", got.accel_y, want.accel_y);
      cmp_field("accel_z", got.accel_z, want.accel_z);
    end
    result_count++;
  endtask

  task automatic send_tick(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t pred;
    int        gap;
    gap = (!tx_calm && $urandom_range(0, 99) < 25) ? pick_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = predict_tick(it);
    expected_pins_q.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_pins_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_half(input logic [7:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    half_ticks = value;
  endtask

  // Result side: checks every result of an accepted item and stalls in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result(out_data_o);
      if ($urandom_range(0, 499) == 0) rx_calm = !rx_calm;
      if (stall_left == 0 && !rx_calm && $urandom_range(0, 99) < 15) stall_left = pick_len();
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** spi_accel_register_master_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    int       phase_halves [8] = '{1, 0, 2, 1, 3, 1, 4, 2};

    // Idle pins, the write set-up half, busy starts, zero and changed half lengths.
    dir_rows.push_back(mk_row(-1, KIND_NONE, 6'd63, 8'd255, 1'b1, 1, FILL_NONE, 1'b1,
                              IDLE_PINS));
    dir_rows.push_back(mk_row(-1, KIND_NONE, 6'd0, 8'd0, 1'b0, 1, FILL_NONE, 1'b1,
                              IDLE_PINS));
    dir_rows.push_back(mk_row(0, KIND_WRITE, 6'd63, 8'd255, 1'b1, 1, FILL_NONE, 1'b1,
                              WRITE_SETUP));
    dir_rows.push_back(mk_row(-1, KIND_READ, 6'd5, 8'd0, 1'b0, 1, FILL_LOW));
    dir_rows.push_back(mk_row(1, KIND_WRITE, 6'd0, 8'd0, 1'b0, 1, FILL_HIGH, 1'b1,
                              WRITE_SETUP));
    dir_rows.push_back(mk_row(2, KIND_READ, 6'd63, 8'd0, 1'b1, 1, FILL_HIGH));
    dir_rows.push_back(mk_row(-1, KIND_READ, 6'd0, 8'd255, 1'b0, 1, FILL_LOW));
    dir_rows.push_back(mk_row(1, KIND_BURST, 6'd0, 8'd0, 1'b1, 1, FILL_HIGH));
    dir_rows.push_back(mk_row(-1, KIND_BURST, 6'd63, 8'd255, 1'b0, 1, FILL_LOW));
    dir_rows.push_back(mk_row(3, KIND_BURST, 6'd21, 8'd170, 1'b1, 1, FILL_RAND));
    // Start a slow read, then shorten the half while the first low half is running.
    dir_rows.push_back(mk_row(8, KIND_READ, 6'd42, 8'd85, 1'b1, 1, FILL_NONE));
    dir_rows.push_back(mk_row(-1, KIND_NONE, 6'd0, 8'd0, 1'b1, 5, FILL_NONE));
    dir_rows.push_back(mk_row(2, KIND_NONE, 6'd0, 8'd0, 1'b0, 1, FILL_RAND));
    // The longest half starts a read that the rows after it finish at a half of one tick.
    dir_rows.push_back(mk_row(255, KIND_READ, 6'd33, 8'd0, 1'b1, 4, FILL_NONE));
    dir_rows.push_back(mk_row(1, KIND_WRITE, 6'd5, 8'd165, 1'b0, 1, FILL_NONE));
    dir_rows.push_back(mk_row(-1, KIND_BURST, 6'd63, 8'd255, 1'b1, 3, FILL_RAND));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_en) write_half(dir_rows[i].cfg_val);
      tx_calm = dir_rows[i].cfg_en && (dir_rows[i].cfg_val == 8'd255);
      for (int n = 0; n < int'(dir_rows[i].reps); n++) begin
        send_tick(dir_rows[i].item, dir_rows[i].typed && n == 0, dir_rows[i].want);
      end
      if (dir_rows[i].fill != FILL_NONE) begin
        while (bus_phase != PH_IDLE) begin
          it.command = KIND_NONE;
          it.reg_addr = 6'($urandom);
          it.write_data = 8'($urandom);
          case (dir_rows[i].fill)
            FILL_LOW: it.miso = 1'b0;
            FILL_HIGH: it.miso = 1'b1;
            default: it.miso = 1'($urandom);
          endcase
          send_tick(it, 1'b0, '0);
        end
      end
    end

    // Random part: when idle most ticks start a transaction; starts while busy are noise.
    foreach (phase_halves[p]) begin
      write_half(8'(phase_halves[p]));
      tx_calm = (p % 4 == 3);
      for (int n = 0; n < 125; n++) begin
        if (p == 4 && n == 110) wait_drained();
        it.reg_addr = 6'($urandom);
        it.write_data = 8'($urandom);
        it.miso = 1'($urandom);
        if (bus_phase == PH_IDLE) begin
          it.command = ($urandom_range(0, 99) < 70) ? 2'($urandom_range(1, 3)) : KIND_NONE;
        end else begin
          it.command = ($urandom_range(0, 99) < 20) ? 2'($urandom_range(1, 3)) : KIND_NONE;
        end
        send_tick(it, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** spi_accel_register_master_unit: PASSED **");
    end else begin
      $display("** spi_accel_register_master_unit: FAILED **");
    end
    $finish;
  end

endmodule
